// ----- rtl/core/sawc_pkg.sv -----
// ----------------------------------------------------------------------------
// sawc_pkg
// Shared types and constants of the cache tag and state engine.
// ----------------------------------------------------------------------------
package sawc_pkg;

    localparam int SETS_MAX   = 8192;
    localparam int WAYS_MAX   = 8;
    localparam int SET_W      = 13;
    localparam int TAG_W      = 31;
    localparam int OFF_W      = 12;
    localparam int WAY_W      = 3;
    localparam int IB_MAX     = 13;
    localparam int OB_MAX     = 12;

    localparam logic [1:0] CFG_WAYS   = 2'd0;
    localparam logic [1:0] CFG_INDEX  = 2'd1;
    localparam logic [1:0] CFG_OFFSET = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE  = 2'd1;
    localparam logic [1:0] ST_MISALIGN  = 2'd2;

    localparam logic [1:0] REFS_HIT   = 2'd0;
    localparam logic [1:0] REFS_MISS  = 2'd1;
    localparam logic [1:0] REFS_DIRTY = 2'd2;

    typedef struct packed {
        logic             op;
        logic [TAG_W-1:0] tag;
        logic [SET_W-1:0] set;
        logic [OFF_W-1:0] off;
        logic [1:0]       status;
    } t_item;

    typedef struct packed {
        logic             hit;
        logic [1:0]       refs;
        logic [TAG_W-1:0] tag;
        logic [SET_W-1:0] set;
        logic [OFF_W-1:0] off;
        logic [1:0]       status;
    } t_result;

    typedef struct packed {
        logic [WAYS_MAX-1:0][TAG_W-1:0] tags;
        logic [WAYS_MAX-1:0]            vld;
        logic [WAYS_MAX-1:0]            dty;
        logic [WAY_W-1:0]               ptr;
    } t_row;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

    typedef enum logic [1:0] {
        S_CLR,
        S_IDLE,
        S_LOOK
    } t_back_state;

    function automatic logic [WAY_W-1:0] next_way(input logic [WAY_W-1:0] w,
                                                  input logic [3:0] ways);
        logic [3:0] n;
        n = {1'b0, w} + 4'd1;
        return (n >= ways) ? '0 : n[WAY_W-1:0];
    endfunction

endpackage

// ----- rtl/core/set_assoc_writeback_cache_tags_core.sv -----
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_tags_core
// Tag and state engine of a set-associative write-back cache.
// ----------------------------------------------------------------------------
// Usage:
//   Accesses go in through a queue port: a beat is taken when i_push is high
//   and o_full is low. One result per access comes out through a queue port:
//   the oldest result shows while o_empty is low and is taken with i_pop.
//   Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) land at once. They are to be
//   made only while the block is idle; the block itself does not enforce this.
//   An accepted beat passes through the input queue, the set row read register
//   and the result queue. An access waits in the input queue until the one
//   before it has read, then written back, its row in the single-port tag memory.
//   After reset a clearing pass writes all 8192 set rows, one set row a cycle,
//   with o_full held high; config writes are still taken.
//   When pop stalls, two results queue up, then two more accesses wait in
//   the input queue before o_full rises.
// ----------------------------------------------------------------------------
module set_assoc_writeback_cache_tags_core
    import sawc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_op,
    input  logic [3:0]  i_access_size,
    input  logic [31:0] i_address,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_hit,
    output logic [1:0]  o_mem_refs,
    output logic [30:0] o_tag_value,
    output logic [12:0] o_set_index,
    output logic [11:0] o_line_offset,
    output logic [1:0]  o_status
);

    t_back_stat stat;
    logic q_valid, q_pop;
    t_item q_item;
    logic [3:0] ways;
    t_result res;

    sawc_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_push, .o_full, .i_op, .i_access_size, .i_address,
        .i_stat(stat), .o_q_valid(q_valid), .i_q_pop(q_pop),
        .o_q_item(q_item), .o_ways(ways)
    );

    sawc_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop),
        .i_q_item(q_item), .i_ways(ways), .o_stat(stat),
        .o_empty, .i_pop, .o_res(res)
    );

    assign o_hit         = res.hit;
    assign o_mem_refs    = res.refs;
    assign o_tag_value   = res.tag;
    assign o_set_index   = res.set;
    assign o_line_offset = res.off;
    assign o_status      = res.status;

endmodule

// ----- rtl/core/sawc_front.sv -----
// ----------------------------------------------------------------------------
// sawc_front
// Config registers, address split, status check and two-beat item queue.
// ----------------------------------------------------------------------------
module sawc_front
    import sawc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_op,
    input  logic [3:0]  i_access_size,
    input  logic [31:0] i_address,
    input  t_back_stat  i_stat,
    output logic        o_q_valid,
    input  logic        i_q_pop,
    output t_item       o_q_item,
    output logic [3:0]  o_ways
);

    logic [3:0] r_way_count, r_index_bits, r_offset_bits;
    logic [3:0] ob, ib;
    logic [4:0] shamt;
    logic [31:0] addr_sh;
    logic [SET_W-1:0] set_mask;
    logic [OFF_W-1:0] off_mask;
    logic [3:0] sz_m1;
    logic sz_ok;
    t_item item;

    t_item r_q [2];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt;
    logic do_push, do_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_way_count   <= 4'd1;
            r_index_bits  <= 4'd1;
            r_offset_bits <= 4'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WAYS:   r_way_count   <= i_cfg_data;
                CFG_INDEX:  r_index_bits  <= i_cfg_data;
                CFG_OFFSET: r_offset_bits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_way_count == 4'd0)
            o_ways = 4'd1;
        else if (r_way_count > 4'(WAYS_MAX))
            o_ways = 4'(WAYS_MAX);
        else
            o_ways = r_way_count;
        ob = (r_offset_bits > 4'(OB_MAX)) ? 4'(OB_MAX) : r_offset_bits;
        if (r_index_bits == 4'd0)
            ib = 4'd1;
        else if (r_index_bits > 4'(IB_MAX))
            ib = 4'(IB_MAX);
        else
            ib = r_index_bits;
        shamt    = {1'b0, ob} + {1'b0, ib};
        addr_sh  = i_address >> ob;
        set_mask = (SET_W'(1) << ib) - SET_W'(1);
        off_mask = (OFF_W'(1) << ob) - OFF_W'(1);
        item.op  = i_op;
        item.off = i_address[OFF_W-1:0] & off_mask;
        item.set = addr_sh[SET_W-1:0] & set_mask;
        item.tag = TAG_W'(i_address >> shamt);
        sz_ok = (i_access_size == 4'd1) || (i_access_size == 4'd2) ||
                (i_access_size == 4'd4) || (i_access_size == 4'd8);
        sz_m1 = i_access_size - 4'd1;
        if (!sz_ok)
            item.status = ST_BAD_SIZE;
        else if ((item.off[3:0] & sz_m1) != 4'd0)
            item.status = ST_MISALIGN;
        else
            item.status = ST_OK;
    end

    assign o_full    = (r_cnt == 2'd2) || i_stat.clearing;
    assign do_push   = i_push && !o_full;
    assign o_q_valid = (r_cnt != 2'd0);
    assign do_pop    = i_q_pop && o_q_valid;
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_q[r_wp] <= item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push)
                r_wp <= ~r_wp;
            if (do_pop)
                r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// ----- rtl/core/sawc_back.sv -----
// ----------------------------------------------------------------------------
// sawc_back
// Set row memory, lookup and update sequencer, two-beat result queue.
// ----------------------------------------------------------------------------
module sawc_back
    import sawc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    output logic        o_q_pop,
    input  t_item       i_q_item,
    input  logic [3:0]  i_ways,
    output t_back_stat  o_stat,
    output logic        o_empty,
    input  logic        i_pop,
    output t_result     o_res
);

    t_row r_mem [SETS_MAX];
    t_row r_row;
    t_item r_item;
    t_back_state r_state, n_state;
    logic [SET_W-1:0] r_clr_idx;

    t_result r_oq [2];
    logic r_owp, r_orp;
    logic [1:0] r_ocnt;
    logic opush, opop;

    logic mem_we, mem_re;
    logic [SET_W-1:0] mem_wa;
    t_row wrow;
    t_result res;
    logic hit_f, inv_f;
    logic [WAY_W-1:0] hit_w, inv_w, victim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_CLR;
        else
            r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_clr_idx <= '0;
        else if (r_state == S_CLR)
            r_clr_idx <= r_clr_idx + SET_W'(1);
    end

    always_comb begin
        hit_f = 1'b0;
        inv_f = 1'b0;
        hit_w = '0;
        inv_w = '0;
        for (int w = WAYS_MAX - 1; w >= 0; w--) begin
            if (4'(w) < i_ways) begin
                if (r_row.vld[w] && r_row.tags[w] == r_item.tag) begin
                    hit_f = 1'b1;
                    hit_w = WAY_W'(w);
                end
                if (!r_row.vld[w]) begin
                    inv_f = 1'b1;
                    inv_w = WAY_W'(w);
                end
            end
        end
        victim = ({1'b0, r_row.ptr} < i_ways) ? r_row.ptr : '0;

        wrow       = r_row;
        res.tag    = r_item.tag;
        res.set    = r_item.set;
        res.off    = r_item.off;
        res.status = r_item.status;
        res.hit    = hit_f;
        res.refs   = REFS_MISS;
        if (hit_f) begin
            res.refs = REFS_HIT;
            if (r_row.ptr == hit_w)
                wrow.ptr = next_way(hit_w, i_ways);
            if (r_item.op)
                wrow.dty[hit_w] = 1'b1;
        end else if (inv_f) begin
            wrow.vld[inv_w]  = 1'b1;
            wrow.tags[inv_w] = r_item.tag;
            wrow.dty[inv_w]  = r_item.op;
            if (r_row.ptr == inv_w)
                wrow.ptr = next_way(inv_w, i_ways);
        end else begin
            if (r_row.dty[victim])
                res.refs = REFS_DIRTY;
            wrow.vld[victim]  = 1'b1;
            wrow.tags[victim] = r_item.tag;
            wrow.dty[victim]  = r_item.op;
            wrow.ptr = next_way(victim, i_ways);
        end

        n_state = r_state;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        mem_wa  = r_item.set;
        opush   = 1'b0;
        unique case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
                mem_wa = r_clr_idx;
                wrow   = '0;
                if (r_clr_idx == SET_W'(SETS_MAX - 1))
                    n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_q_valid && r_ocnt != 2'd2) begin
                    mem_re  = 1'b1;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                mem_we  = 1'b1;
                opush   = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_CLR;
        endcase
    end

    assign o_q_pop = mem_re;
    assign o_stat.clearing = (r_state == S_CLR);

    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_mem[mem_wa] <= wrow;
        if (mem_re) begin
            r_row  <= r_mem[i_q_item.set];
            r_item <= i_q_item;
        end
    end

    assign o_empty = (r_ocnt == 2'd0);
    assign opop    = i_pop && !o_empty;
    assign o_res   = r_oq[r_orp];

    always_ff @(posedge i_clk) begin
        if (opush)
            r_oq[r_owp] <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (opush)
                r_owp <= ~r_owp;
            if (opop)
                r_orp <= ~r_orp;
            r_ocnt <= r_ocnt + 2'(opush) - 2'(opop);
        end
    end

    a_ocnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= 2'd2) else $error("result queue overrun");
    a_look_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> (r_ocnt != 2'd2)) else $error("no room for result");
    a_look_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |=> (r_state == S_IDLE)) else $error("lookup overstayed");
    a_no_pop_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_q_pop) else $error("item taken while clearing");

endmodule
